// ===== rtl/core/cbf_pkg.sv =====
// Shared constants for the cascaded biquad filter and its checker.
package cbf_pkg;

    // Coefficient registers are signed Q4.F words.
    localparam int COEF_W     = 20;
    // Delay words of both sections.
    localparam int DELAY_W    = 40;
    // Width of the configuration register index.
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_A0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd4;

    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [DELAY_W-1:0] delay_t;

endpackage

// ===== rtl/core/cascaded_biquad_filter.sv =====
// Two cascaded transposed direct form II biquad sections on one shared multiplier.
//
//   channel   signals                                   direction  handshake
//   input     input_sample, end_of_block                in         in_valid / in_stall
//   output    filtered_sample, end_of_block_out,        out        out_valid / out_stall
//             saturated
//   config    cfg_index, cfg_data                       in         cfg_valid / cfg_ready
//
// One sample occupies the block for eight sequencer steps per section on the
// single multiply-accumulate unit (five products, the rounding step and two delay
// writes), after it is accepted. in_stall is high while a sample is being worked on.
// A finished result waits in the output register; if it is still held when the next
// one finishes, the sequencer waits on its last step. Reset clears the coefficients
// to unity gain, all four delay words and the control state.
module cascaded_biquad_filter
    import cbf_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Sample input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] input_sample,
    input  logic                          end_of_block,
    // Result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] filtered_sample,
    output logic                          end_of_block_out,
    output logic                          saturated,
    // Coefficient writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [COEF_W-1:0]             cfg_data
);

    localparam int PROD_W = SAMPLE_BITS + COEF_W;
    localparam int WIDE_W = (PROD_W > DELAY_W) ? PROD_W : DELAY_W;
    localparam int ACC_W  = WIDE_W + 2;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SMP_MAX  = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [ACC_W-1:0] SMP_MIN  = -SMP_MAX - 1;
    localparam logic signed [ACC_W-1:0] DLY_MAX  = (ACC_W'(1) <<< (DELAY_W - 1)) - 1;
    localparam logic signed [ACC_W-1:0] DLY_MIN  = -DLY_MAX - 1;
    localparam logic [COEF_W-1:0]       A0_RESET = COEF_W'(1) << COEF_FRAC_BITS;

    // Sequencer state.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Steps within one section.
    localparam logic [2:0] PH_ISSUE_A0 = 3'd0;
    localparam logic [2:0] PH_ACC_D0   = 3'd1;
    localparam logic [2:0] PH_ROUND    = 3'd2;
    localparam logic [2:0] PH_ISSUE_B1 = 3'd3;
    localparam logic [2:0] PH_SUB_B1   = 3'd4;
    localparam logic [2:0] PH_WR_D0    = 3'd5;
    localparam logic [2:0] PH_SUB_B2   = 3'd6;
    localparam logic [2:0] PH_WR_D1    = 3'd7;

    localparam logic [3:0] STEP_LAST = 4'd15;

    logic                          state_reg;
    logic [3:0]                    step_reg;
    logic                          sec;
    logic [2:0]                    phase;

    coef_t                         a0_reg, a1_reg, a2_reg, b1_reg, b2_reg;
    delay_t                        s1d0_reg, s1d1_reg, s2d0_reg, s2d1_reg;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic                          eob_reg;
    logic                          sat_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] filtered_reg;
    logic                          eob_out_reg;
    logic                          sat_out_reg;

    logic                          accept;
    logic                          out_free;
    logic                          last_step;
    logic                          finish;
    logic                          advance;

    coef_t                         mul_coef;
    logic signed [SAMPLE_BITS-1:0] mul_opnd;
    logic signed [PROD_W-1:0]      mul_result;
    delay_t                        d0_sel;
    delay_t                        d1_sel;
    logic signed [ACC_W-1:0]       rnd_sum;
    logic signed [ACC_W-1:0]       rnd_val;
    logic                          y_clip;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          d_clip;
    delay_t                        d_sat;

    assign sec   = step_reg[3];
    assign phase = step_reg[2:0];

    // Handshake decode.
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_step = (state_reg == ST_RUN) && (step_reg == STEP_LAST);
    assign finish    = last_step && out_free;
    assign advance   = (state_reg == ST_RUN) && !(last_step && !out_free);

    assign in_stall         = (state_reg == ST_RUN);
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign filtered_sample  = filtered_reg;
    assign end_of_block_out = eob_out_reg;
    assign saturated        = sat_out_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_coef = a0_reg;
        mul_opnd = x_reg;
        case (phase)
            PH_ISSUE_A0:
            begin
                mul_coef = a0_reg;
                mul_opnd = x_reg;
            end
            PH_ACC_D0:
            begin
                mul_coef = a1_reg;
            end
            PH_ISSUE_B1:
            begin
                mul_coef = b1_reg;
                mul_opnd = y_reg;
            end
            PH_SUB_B1:
            begin
                mul_coef = a2_reg;
            end
            PH_WR_D0:
            begin
                mul_coef = b2_reg;
                mul_opnd = y_reg;
            end
            default:
            begin
                mul_coef = a0_reg;
                mul_opnd = x_reg;
            end
        endcase
    end

    assign mul_result = PROD_W'(mul_coef) * PROD_W'(mul_opnd);

    // Delay words of the section in progress.
    assign d0_sel = sec ? s2d0_reg : s1d0_reg;
    assign d1_sel = sec ? s2d1_reg : s1d1_reg;

    // Round half up, then clip to the sample range.
    always_comb
    begin
        rnd_sum = acc_reg + RND_HALF;
        rnd_val = rnd_sum >>> COEF_FRAC_BITS;
        y_clip  = (rnd_val > SMP_MAX) || (rnd_val < SMP_MIN);
        if (rnd_val > SMP_MAX)
        begin
            y_sat = SMP_MAX[SAMPLE_BITS-1:0];
        end
        else if (rnd_val < SMP_MIN)
        begin
            y_sat = SMP_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            y_sat = rnd_val[SAMPLE_BITS-1:0];
        end
    end

    // Clip the accumulator to the delay word range.
    always_comb
    begin
        d_clip = (acc_reg > DLY_MAX) || (acc_reg < DLY_MIN);
        if (acc_reg > DLY_MAX)
        begin
            d_sat = DLY_MAX[DELAY_W-1:0];
        end
        else if (acc_reg < DLY_MIN)
        begin
            d_sat = DLY_MIN[DELAY_W-1:0];
        end
        else
        begin
            d_sat = acc_reg[DELAY_W-1:0];
        end
    end

    // Sequencer and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_RUN;
                        step_reg  <= '0;
                    end
                end
                ST_RUN:
                begin
                    if (finish)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (advance)
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Coefficient registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_reg <= A0_RESET;
            a1_reg <= '0;
            a2_reg <= '0;
            b1_reg <= '0;
            b2_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_A0:  a0_reg <= cfg_data;
                REG_A1:  a1_reg <= cfg_data;
                REG_A2:  a2_reg <= cfg_data;
                REG_B1:  b1_reg <= cfg_data;
                REG_B2:  b2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Delay words; written when the sequencer writes back a section.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1d0_reg <= '0;
            s1d1_reg <= '0;
            s2d0_reg <= '0;
            s2d1_reg <= '0;
        end
        else if (state_reg == ST_RUN)
        begin
            if (phase == PH_WR_D0)
            begin
                if (sec)
                begin
                    s2d0_reg <= d_sat;
                end
                else
                begin
                    s1d0_reg <= d_sat;
                end
            end
            else if (phase == PH_WR_D1)
            begin
                if (sec)
                begin
                    s2d1_reg <= d_sat;
                end
                else
                begin
                    s1d1_reg <= d_sat;
                end
            end
        end
    end

    // Multiply-accumulate datapath.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_result;
        if (accept)
        begin
            x_reg   <= input_sample;
            eob_reg <= end_of_block;
            sat_reg <= 1'b0;
        end
        else if (state_reg == ST_RUN)
        begin
            case (phase)
                PH_ACC_D0:
                begin
                    acc_reg <= ACC_W'(d0_sel) + ACC_W'(prod_reg);
                end
                PH_ROUND:
                begin
                    y_reg   <= y_sat;
                    sat_reg <= sat_reg | y_clip;
                    acc_reg <= ACC_W'(d1_sel) + ACC_W'(prod_reg);
                end
                PH_SUB_B1:
                begin
                    acc_reg <= acc_reg - ACC_W'(prod_reg);
                end
                PH_WR_D0:
                begin
                    sat_reg <= sat_reg | d_clip;
                    acc_reg <= ACC_W'(prod_reg);
                end
                PH_SUB_B2:
                begin
                    acc_reg <= acc_reg - ACC_W'(prod_reg);
                end
                PH_WR_D1:
                begin
                    // The first section's result feeds the second section.
                    if (!sec)
                    begin
                        x_reg   <= y_reg;
                        sat_reg <= sat_reg | d_clip;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register, loaded when the second section completes.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            filtered_reg <= y_reg;
            eob_out_reg  <= eob_reg;
            sat_out_reg  <= sat_reg | d_clip;
        end
    end

endmodule

// ===== rtl/core/cbf_checker.sv =====
// Port-level checks for the cascaded biquad filter, bound into the filter module.
module cbf_checker
    import cbf_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] filtered_sample,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [CFG_IDX_W-1:0]          cfg_index
);

    // A request taken makes the block busy for the following cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a request was taken");

    // The block only turns busy because it took a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("input stall rose without a request");

    // A new result appears exactly when the block becomes free again.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $fell(in_stall))
        else $error("result appeared without the sample finishing");

    // A held result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(filtered_sample)))
        else $error("stalled result changed");

    // Coefficient writes are always taken and carry a known register index.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> (cfg_ready && !$isunknown(cfg_index)))
        else $error("coefficient write refused or with an unknown index");

endmodule

bind cascaded_biquad_filter cbf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cbf_checker (.*);
